// ----- hw/rtl/pss_pkg.sv -----
package pss_pkg;

   localparam int MAX_DELAY_DEF = 4096;
   localparam int FRAC_BITS_DEF = 8;

   localparam int LEN_CFG_W = 13;
   localparam int COEF_W    = 16;

   localparam logic [COEF_W-1:0] GAIN_ONE = 16'h8000;

   localparam logic [LEN_CFG_W-1:0]     DELAY_LENGTH_RST  = 13'd100;
   localparam logic [COEF_W-1:0]        DECAY_GAIN_RST    = 16'd32440;
   localparam logic signed [COEF_W-1:0] ALLPASS_COEFF_RST = 16'sd0;
   localparam logic [COEF_W-1:0]        LOWPASS_GAIN_RST  = 16'd16384;

   typedef enum logic [1:0] {
      CSR_DELAY_LENGTH,
      CSR_DECAY_GAIN,
      CSR_ALLPASS_COEFF,
      CSR_LOWPASS_GAIN
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_DECAY,
      ST_ADD_DECAY,
      ST_MUL_LOWPASS,
      ST_ADD_LOWPASS,
      ST_MUL_ALLPASS,
      ST_ADD_ALLPASS
   } voice_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef struct packed {
      logic [LEN_CFG_W-1:0]     delay_length;
      logic [COEF_W-1:0]        decay_gain;
      logic signed [COEF_W-1:0] allpass_coeff;
      logic [COEF_W-1:0]        lowpass_gain;
   } csr_regs_type;

endpackage

// ----- hw/rtl/pss_delay_mem.sv -----
module pss_delay_mem
   import pss_pkg::*;
#(
   parameter int DEPTH = MAX_DELAY_DEF,
   parameter int AW    = $clog2(MAX_DELAY_DEF),
   parameter int DW    = 16 + FRAC_BITS_DEF
) (
   input  logic          clock,
   input  mem_ctl_type   mem_ctl,
   input  logic [AW-1:0] raddr,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/pss_voice_core.sv -----
module pss_voice_core
   import pss_pkg::*;
#(
   parameter int MAX_DELAY = MAX_DELAY_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  csr_regs_type       csr,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_excitation,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample_out
);

   localparam int SW    = 16 + FRAC_BITS;
   localparam int PW    = $clog2(MAX_DELAY);
   localparam int LW    = $clog2(MAX_DELAY + 1);
   localparam int CW    = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
   localparam int MAW   = SW + 1;
   localparam int MBW   = COEF_W + 1;
   localparam int PRODW = MAW + MBW;

   localparam logic signed [PRODW-1:0] SAT_HI = {{(PRODW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [PRODW-1:0] SAT_LO = {{(PRODW-SW+1){1'b1}}, {(SW-1){1'b0}}};
   localparam logic [SW:0]             RND_MASK = (SW+1)'((64'd1 << FRAC_BITS) - 64'd1);

   function automatic logic signed [SW-1:0] sat_sample(input logic signed [PRODW-1:0] x);
      logic signed [SW-1:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[SW-1:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[SW-1:0];
      end else begin
         r = x[SW-1:0];
      end
      return r;
   endfunction

   voice_state_type state_ff, state_in;

   logic [PW-1:0]        ptr_ff;
   logic [LW-1:0]        fill_ff;
   logic [PW-1:0]        cur_ptr_ff;
   logic                 hit_ff;
   logic signed [15:0]   ex_ff;
   logic signed [SW-1:0] lp_prev_ff;
   logic signed [SW-1:0] ap_in_ff;
   logic signed [SW-1:0] ap_out_ff;
   logic signed [SW-1:0] v_ff;
   logic signed [SW-1:0] lp_ff;
   logic signed [PRODW-1:0] prod_ff;
   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_sample_ff;

   logic [CW-1:0]        cfg_len_wide;
   logic [LW-1:0]        len_eff;
   logic                 accept;
   logic                 done;
   logic [PW-1:0]        ptr_start;
   logic [LW-1:0]        fill_start;
   logic                 hit_start;
   logic [LW-1:0]        ptr_next_wide;
   logic [COEF_W-1:0]    decay_clamped;
   logic [COEF_W-1:0]    lowpass_clamped;
   logic signed [MAW-1:0] mul_a;
   logic signed [MBW-1:0] mul_b;
   logic signed [PRODW-1:0] shifted;
   logic signed [PRODW-1:0] add_term;
   logic signed [PRODW-1:0] sum;
   logic signed [SW-1:0] sat_out;
   logic signed [SW:0]   y_adj;
   mem_ctl_type          mem_ctl;
   logic [SW-1:0]        mem_rdata;

   assign cfg_len_wide = CW'(csr.delay_length);

   always_comb begin
      if (cfg_len_wide == '0) begin
         len_eff = LW'(1);
      end else if (cfg_len_wide > CW'(MAX_DELAY)) begin
         len_eff = LW'(MAX_DELAY);
      end else begin
         len_eff = cfg_len_wide[LW-1:0];
      end
   end

   assign decay_clamped   = (csr.decay_gain > GAIN_ONE) ? GAIN_ONE : csr.decay_gain;
   assign lowpass_clamped = (csr.lowpass_gain > GAIN_ONE) ? GAIN_ONE : csr.lowpass_gain;

   always_comb begin
      if (req_restart || (LW'(ptr_ff) >= len_eff)) begin
         ptr_start = '0;
      end else begin
         ptr_start = ptr_ff;
      end
      fill_start = req_restart ? '0 : fill_ff;
      hit_start  = LW'(ptr_start) < fill_start;
   end

   assign ptr_next_wide = LW'(cur_ptr_ff) + LW'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_MUL_DECAY;
         ST_MUL_DECAY:   state_in = ST_ADD_DECAY;
         ST_ADD_DECAY:   state_in = ST_MUL_LOWPASS;
         ST_MUL_LOWPASS: state_in = ST_ADD_LOWPASS;
         ST_ADD_LOWPASS: state_in = ST_MUL_ALLPASS;
         ST_MUL_ALLPASS: state_in = ST_ADD_ALLPASS;
         ST_ADD_ALLPASS: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      done          = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_ctl.wr_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            mem_ctl.rd_en = req_valid;
         end
         ST_ADD_ALLPASS: begin
            done          = !rsp_valid_ff || rsp_ready;
            mem_ctl.wr_en = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_DECAY: begin
            mul_a = hit_ff ? MAW'(signed'(mem_rdata)) : '0;
            mul_b = MBW'(decay_clamped);
         end
         ST_MUL_LOWPASS: begin
            mul_a = MAW'(v_ff) + MAW'(lp_prev_ff);
            mul_b = MBW'(lowpass_clamped);
         end
         ST_MUL_ALLPASS: begin
            mul_a = MAW'(lp_ff) - MAW'(ap_out_ff);
            mul_b = MBW'(csr.allpass_coeff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign shifted = prod_ff >>> 15;

   always_comb begin
      case (state_ff)
         ST_ADD_DECAY:   add_term = PRODW'(ex_ff) <<< FRAC_BITS;
         ST_ADD_ALLPASS: add_term = PRODW'(ap_in_ff);
         default:        add_term = '0;
      endcase
   end

   assign sum     = shifted + add_term;
   assign sat_out = sat_sample(sum);
   assign y_adj   = (SW+1)'(sat_out) + (sat_out[SW-1] ? RND_MASK : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         lp_prev_ff   <= '0;
         ap_in_ff     <= '0;
         ap_out_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            fill_ff <= fill_start;
            if (req_restart) begin
               lp_prev_ff <= '0;
               ap_in_ff   <= '0;
               ap_out_ff  <= '0;
            end
         end
         if (state_ff == ST_MUL_LOWPASS) begin
            lp_prev_ff <= v_ff;
         end
         if (done) begin
            ap_in_ff  <= lp_ff;
            ap_out_ff <= sat_out;
            if (ptr_next_wide > fill_ff) begin
               fill_ff <= ptr_next_wide;
            end
            ptr_ff <= (ptr_next_wide >= len_eff) ? '0 : ptr_next_wide[PW-1:0];
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ptr_ff <= ptr_start;
         hit_ff     <= hit_start;
         ex_ff      <= req_excitation;
      end
      if ((state_ff == ST_MUL_DECAY) || (state_ff == ST_MUL_LOWPASS)
          || (state_ff == ST_MUL_ALLPASS)) begin
         prod_ff <= PRODW'(mul_a) * PRODW'(mul_b);
      end
      if (state_ff == ST_ADD_DECAY) begin
         v_ff <= sat_out;
      end
      if (state_ff == ST_ADD_LOWPASS) begin
         lp_ff <= sat_out;
      end
      if (done) begin
         rsp_sample_ff <= y_adj[FRAC_BITS+15:FRAC_BITS];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   pss_delay_mem #(
      .DEPTH(MAX_DELAY),
      .AW   (PW),
      .DW   (SW)
   ) u_delay_mem (
      .clock  (clock),
      .mem_ctl(mem_ctl),
      .raddr  (ptr_start),
      .waddr  (cur_ptr_ff),
      .wdata  (sat_out),
      .rdata  (mem_rdata)
   );

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL_DECAY)
      else $error("An accepted transfer did not start the decay multiply.");

   a_write_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |=> rsp_valid_ff)
      else $error("A delay line write-back did not produce a result.");

   a_fill_covers_write: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |=> fill_ff > LW'($past(cur_ptr_ff)))
      else $error("The fill count does not cover the slot just written.");

endmodule

// ----- hw/rtl/plucked_string_synth_unit.sv -----
// Each sample passes from acceptance to result through the delay line read issued with the
// transfer, then three multiply and add steps that share one multiplier, each waiting on the last.
// The next sample is accepted in the cycle after the result is loaded, so a new sample is not
// taken before the last one is through; a held result stalls only the final step.
// Reset is synchronous and active high; it restores the register defaults, clears the
// filter state and marks the whole delay line unfilled, with no clearing pass.
module plucked_string_synth_unit
   import pss_pkg::*;
#(
   parameter int MAX_DELAY = MAX_DELAY_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_excitation,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   csr_regs_type  csr_ff;
   csr_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.delay_length  <= DELAY_LENGTH_RST;
         csr_ff.decay_gain    <= DECAY_GAIN_RST;
         csr_ff.allpass_coeff <= ALLPASS_COEFF_RST;
         csr_ff.lowpass_gain  <= LOWPASS_GAIN_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DELAY_LENGTH:  csr_ff.delay_length  <= pwdata[LEN_CFG_W-1:0];
            CSR_DECAY_GAIN:    csr_ff.decay_gain    <= pwdata[COEF_W-1:0];
            CSR_ALLPASS_COEFF: csr_ff.allpass_coeff <= pwdata[COEF_W-1:0];
            CSR_LOWPASS_GAIN:  csr_ff.lowpass_gain  <= pwdata[COEF_W-1:0];
            default:           csr_ff.lowpass_gain  <= csr_ff.lowpass_gain;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DELAY_LENGTH:  prdata = 32'(csr_ff.delay_length);
         CSR_DECAY_GAIN:    prdata = 32'(csr_ff.decay_gain);
         CSR_ALLPASS_COEFF: prdata = 32'(unsigned'(csr_ff.allpass_coeff));
         CSR_LOWPASS_GAIN:  prdata = 32'(csr_ff.lowpass_gain);
         default:           prdata = '0;
      endcase
   end

   pss_voice_core #(
      .MAX_DELAY(MAX_DELAY),
      .FRAC_BITS(FRAC_BITS)
   ) u_voice_core (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_excitation(req_excitation),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample_out(rsp_sample_out)
   );

endmodule

// ----- tb/plucked_string_synth_unit_tb.sv -----
module plucked_string_synth_unit_tb;
   import pss_pkg::*;

   localparam int MAX_DELAY = MAX_DELAY_DEF;
   localparam int FRAC_BITS = FRAC_BITS_DEF;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (15 + FRAC_BITS)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam int QUIET_CYCLES = 12;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_SAMPLES = 1700;

   typedef enum int {
      SINK_ALWAYS,
      SINK_MOSTLY,
      SINK_RARELY,
      SINK_COMB,
      SINK_LONG_STALL
   } sink_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_excitation = '0;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   plucked_string_synth_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_excitation(req_excitation),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   csr_regs_type       voice_cfg;
   logic signed [23:0] string_line [MAX_DELAY];
   int unsigned        line_pos = 0;
   int unsigned        filled_slots = 0;
   logic signed [23:0] lowpass_hist = '0;
   logic signed [23:0] allpass_in_hist = '0;
   logic signed [23:0] allpass_out_hist = '0;

   logic signed [15:0] expected_samples [$];
   int errors = 0;
   int samples_sent = 0;
   int samples_checked = 0;
   int restarts_sent = 0;
   int notes_played = 0;
   int csr_writes = 0;
   int burst_left = 0;
   bit gaps_enabled = 1'b1;
   int idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint sat_internal(input longint x);
      if (x > SAMPLE_MAX) return SAMPLE_MAX;
      if (x < SAMPLE_MIN) return SAMPLE_MIN;
      return x;
   endfunction

   function automatic longint gain_limited(input logic [15:0] g);
      return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
   endfunction

   function automatic logic signed [15:0] string_voice_next(input logic signed [15:0] excitation,
                                                            input logic restart);
      longint tap, fed, smooth, tuned, coarse;
      int unsigned span;
      if (restart) begin
         lowpass_hist = '0;
         allpass_in_hist = '0;
         allpass_out_hist = '0;
         filled_slots = 0;
         line_pos = 0;
      end
      span = voice_cfg.delay_length;
      if (span == 0) span = 1;
      if (span > MAX_DELAY) span = MAX_DELAY;
      if (line_pos >= span) line_pos = 0;
      tap = (line_pos < filled_slots) ? longint'(string_line[line_pos]) : 0;
      fed = sat_internal(((tap * gain_limited(voice_cfg.decay_gain)) >>> 15)
                         + (longint'(excitation) <<< FRAC_BITS));
      smooth = sat_internal(((fed + longint'(lowpass_hist))
                             * gain_limited(voice_cfg.lowpass_gain)) >>> 15);
      lowpass_hist = fed[23:0];
      tuned = sat_internal(((longint'($signed(voice_cfg.allpass_coeff))
                             * (smooth - longint'(allpass_out_hist))) >>> 15)
                           + longint'(allpass_in_hist));
      allpass_in_hist = smooth[23:0];
      allpass_out_hist = tuned[23:0];
      string_line[line_pos] = tuned[23:0];
      if (line_pos + 1 > filled_slots) filled_slots = line_pos + 1;
      line_pos = (line_pos + 1 >= span) ? 0 : line_pos + 1;
      coarse = (tuned >= 0) ? (tuned >>> FRAC_BITS) : -((-tuned) >>> FRAC_BITS);
      return coarse[15:0];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         samples_checked++;
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample_out transfer, expected none, got %0d",
                     $time, rsp_sample_out);
            errors++;
         end else if (rsp_sample_out !== expected_samples[0]) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, expected_samples[0], rsp_sample_out);
            errors++;
            void'(expected_samples.pop_front());
         end else begin
            void'(expected_samples.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("plucked_string_synth_unit_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin : result_sink
      sink_mode_type mode;
      int span_left;
      forever begin
         mode = sink_mode_type'($urandom_range(0, 4));
         span_left = $urandom_range(40, 300);
         while (span_left > 0) begin
            @(negedge clock);
            span_left--;
            case (mode)
               SINK_ALWAYS: rsp_ready <= 1'b1;
               SINK_MOSTLY: rsp_ready <= ($urandom_range(0, 9) < 8);
               SINK_RARELY: rsp_ready <= ($urandom_range(0, 9) < 3);
               SINK_COMB: rsp_ready <= ((span_left % 4) != 1);
               default: rsp_ready <= ((span_left % 32) < 4);
            endcase
         end
      end
   end

   task automatic send_sample(input logic signed [15:0] excitation, input logic restart);
      int pause;
      if (burst_left == 0) begin
         pause = gaps_enabled ? $urandom_range(0, 12) : 0;
         burst_left = $urandom_range(1, 24);
         if (pause > 0) begin
            req_valid <= 1'b0;
            repeat (pause) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_excitation <= excitation;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(string_voice_next(excitation, restart));
      samples_sent++;
      if (restart) restarts_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_DELAY_LENGTH: voice_cfg.delay_length = value[LEN_CFG_W-1:0];
         CSR_DECAY_GAIN: voice_cfg.decay_gain = value[COEF_W-1:0];
         CSR_ALLPASS_COEFF: voice_cfg.allpass_coeff = value[COEF_W-1:0];
         default: voice_cfg.lowpass_gain = value[COEF_W-1:0];
      endcase
      csr_writes++;
   endtask

   task automatic set_voice(input logic [12:0] length, input logic [15:0] decay,
                            input logic [15:0] coeff, input logic [15:0] smoothing);
      wait_for_quiet();
      write_csr(CSR_DELAY_LENGTH, {19'd0, length});
      write_csr(CSR_DECAY_GAIN, {16'd0, decay});
      write_csr(CSR_ALLPASS_COEFF, {16'd0, coeff});
      write_csr(CSR_LOWPASS_GAIN, {16'd0, smoothing});
   endtask

   task automatic test_reset_defaults();
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd200, 1'b1);
      send_sample(16'sd0, 1'b0);
   endtask

   task automatic test_excitation_extremes();
      set_voice(13'd2, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(-16'sh8000, 1'b0);
      send_sample(-16'sh8000, 1'b0);
      send_sample(-16'sd1, 1'b0);
   endtask

   task automatic test_length_extremes();
      set_voice(13'd0, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'sd1000, 1'b1);
      send_sample(-16'sd1000, 1'b0);
      send_sample(16'sd7, 1'b0);
      set_voice(13'h1FFF, 16'd32440, 16'h0000, 16'd16384);
      send_sample(16'sd12345, 1'b1);
      send_sample(-16'sd321, 1'b0);
   endtask

   task automatic test_gain_zero();
      set_voice(13'd1, 16'h0000, 16'h4000, 16'h0000);
      send_sample(16'sd20000, 1'b1);
      send_sample(-16'sd20000, 1'b0);
   endtask

   task automatic test_length_change_midnote();
      set_voice(13'd8, 16'h8000, 16'hC000, 16'd16384);
      send_sample(16'sd5000, 1'b1);
      send_sample(-16'sd3000, 1'b0);
      send_sample(16'sd2500, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd77, 1'b0);
      set_voice(13'd3, 16'h8000, 16'hC000, 16'd16384);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
   endtask

   task automatic test_random_notes(input int target);
      int stop_at, note_len, span, i, pick;
      logic [12:0] length;
      logic [15:0] decay, coeff, smoothing;
      logic signed [15:0] excitation;
      logic restart;
      bit fresh;
      stop_at = samples_sent + target;
      while (samples_sent < stop_at) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) length = 13'd0;
         else if (pick == 1) length = 13'($urandom_range(4097, 8191));
         else if (pick == 2) length = 13'd4096;
         else if (pick < 5) length = 13'($urandom_range(49, 700));
         else length = 13'($urandom_range(1, 48));
         pick = $urandom_range(0, 9);
         if (pick == 0) decay = 16'h0000;
         else if (pick == 1) decay = 16'hFFFF;
         else if (pick == 2) decay = GAIN_ONE;
         else if (pick == 3) decay = 16'($urandom_range(0, 65535));
         else decay = 16'($urandom_range(30000, 32768));
         pick = $urandom_range(0, 9);
         if (pick == 0) coeff = 16'h8000;
         else if (pick == 1) coeff = 16'h7FFF;
         else if (pick == 2) coeff = 16'h0000;
         else coeff = 16'($urandom_range(0, 65535));
         pick = $urandom_range(0, 9);
         if (pick == 0) smoothing = 16'h0000;
         else if (pick == 1) smoothing = 16'hFFFF;
         else if (pick == 2) smoothing = GAIN_ONE;
         else if (pick == 3) smoothing = 16'($urandom_range(0, 65535));
         else smoothing = 16'($urandom_range(14000, 20000));
         set_voice(length, decay, coeff, smoothing);
         gaps_enabled = ($urandom_range(0, 3) != 0);
         fresh = ($urandom_range(0, 4) != 0);
         span = (length == 0) ? 1 : ((length > MAX_DELAY) ? MAX_DELAY : length);
         note_len = (span > 700) ? $urandom_range(10, 30) : $urandom_range(30, 160);
         for (i = 0; i < note_len; i++) begin
            restart = (i == 0) ? fresh : ($urandom_range(0, 99) == 0);
            if (i < span || $urandom_range(0, 19) == 0)
               excitation = $signed(16'($urandom_range(0, 65535))) >>> $urandom_range(0, 6);
            else
               excitation = 16'sd0;
            send_sample(excitation, restart);
            if ($urandom_range(0, 199) == 0) wait_for_quiet();
         end
         notes_played++;
      end
   endtask

   initial begin
      voice_cfg.delay_length = DELAY_LENGTH_RST;
      voice_cfg.decay_gain = DECAY_GAIN_RST;
      voice_cfg.allpass_coeff = ALLPASS_COEFF_RST;
      voice_cfg.lowpass_gain = LOWPASS_GAIN_RST;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_excitation_extremes();
      test_length_extremes();
      test_gain_zero();
      test_length_change_midnote();
      test_random_notes(RANDOM_SAMPLES);
      wait_for_quiet();
      $display("Sent %0d samples over %0d random notes, %0d with restart, %0d register writes.",
               samples_sent, notes_played, restarts_sent, csr_writes);
      $display("Checked %0d output samples, %0d mismatches.", samples_checked, errors);
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("plucked_string_synth_unit_tb OK");
      end else begin
         $display("plucked_string_synth_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
